FILE: rtl/core/code_range_table_top_macros.svh
// assertion macros used by the code range table top
`ifndef CODE_RANGE_TABLE_TOP_MACROS_SVH
`define CODE_RANGE_TABLE_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define CRT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CRT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/crt_pkg.sv
`default_nettype none
package crt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    typedef logic [CW-1:0] t_cnt;
    typedef logic [AW:0]   t_maddr;

    // one table entry
    typedef struct packed {
        logic [63:0] start;
        logic [63:0] stop;
        logic [31:0] image;
        logic [63:0] base;
    } t_entry;

    // write port bundle into the table memory
    typedef struct packed {
        logic   en;
        t_maddr addr;
        t_entry data;
    } t_mem_wr;

    typedef enum logic [1:0] {
        OP_ADD          = 2'd0,
        OP_REMOVE       = 2'd1,
        OP_REMOVE_IMAGE = 2'd2,
        OP_LOOKUP       = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_NONE  = 2'd2,
        STAT_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_INS,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        PH_A,
        PH_B,
        PH_C
    } t_phase;

endpackage
`default_nettype wire

FILE: rtl/core/crt_mem.sv
`default_nettype none
module crt_mem import crt_pkg::*; (
    input  wire logic    i_clk,
    input  wire t_mem_wr i_wr,
    input  wire t_maddr  i_raddr,
    output t_entry       o_rdata
);

    // two banks: the live table and the one being rebuilt
    t_entry r_mem [2*TABLE_ENTRIES];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: rtl/core/code_range_table_top.sv
`default_nettype none
// channel   dir  tdata (low bit up)                                     tuser
// s_axis    in   range_start, range_stop, image_tag, load_base, query_pc  operation
// m_axis    out  hit_image, pc_offset                                   hit, status
//
// one transaction at a time; each is a scan of the live bank, one entry a cycle
// lookup and remove image: one pass; add: a pass, the insert, then a second pass
// remove interval: up to three passes; empty or full refusals go straight to the result
// updates rebuild into the spare bank of the table memory, then swap banks
// after reset the table is empty; a stalled result holds the next transaction
`include "code_range_table_top_macros.svh"
module code_range_table_top import crt_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // range_start, range_stop, image_tag, load_base, query_pc
    input  wire logic [287:0] s_axis_tdata,
    // operation
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // hit_image, pc_offset
    output logic [95:0]       m_axis_tdata,
    // hit, status
    output logic [2:0]        m_axis_tuser
);

    t_state  r_state, n_state;
    t_phase  r_phase, n_phase;
    t_op     r_op, n_op;
    logic    [63:0] r_s, n_s, r_e, n_e, r_b, n_b, r_pc, n_pc;
    logic    [31:0] r_img, n_img;
    logic    r_bank, n_bank;
    t_cnt    r_cnt, n_cnt, r_ridx, n_ridx, r_widx, n_widx;
    logic    r_rv, n_rv, r_any, n_any, r_ovf, n_ovf, r_lf, n_lf, r_skip, n_skip;
    t_status r_stat, n_stat;
    logic    [63:0] r_lstop, n_lstop, r_lbase, n_lbase;
    logic    [31:0] r_limg, n_limg;
    logic    r_ovalid, n_ovalid, r_ohit, n_ohit;
    logic    [31:0] r_oimg, n_oimg;
    logic    [63:0] r_ooff, n_ooff;
    t_status r_ostat, n_ostat;

    t_mem_wr w_wr;
    t_maddr  w_raddr;
    t_entry  w_rd;
    logic    w_issue, w_ov, w_emit, w_commit, w_in_acc, w_out_free;
    t_entry  w_emit_data;

    crt_mem u_mem (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_ovalid || m_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_ooff, r_oimg};
    assign m_axis_tuser  = {r_ostat, r_ohit};

    // read side of the scan
    assign w_issue = (r_state == S_SCAN) && (r_ridx < r_cnt);
    assign w_raddr = {r_bank, r_ridx[AW-1:0]};
    assign w_ov    = (w_rd.image == r_img) && (r_e > w_rd.start) && (r_s < w_rd.stop);

    // sequencer, scan evaluation and result
    always_comb begin
        n_state = r_state;  n_phase = r_phase;  n_op = r_op;
        n_s = r_s;  n_e = r_e;  n_b = r_b;  n_pc = r_pc;  n_img = r_img;
        n_bank = r_bank;  n_cnt = r_cnt;  n_ridx = r_ridx;  n_widx = r_widx;
        n_rv = 1'b0;  n_any = r_any;  n_ovf = r_ovf;  n_lf = r_lf;
        n_skip = r_skip;  n_stat = r_stat;
        n_lstop = r_lstop;  n_lbase = r_lbase;  n_limg = r_limg;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_ohit = r_ohit;  n_oimg = r_oimg;  n_ooff = r_ooff;  n_ostat = r_ostat;
        w_emit = 1'b0;
        w_emit_data = w_rd;
        w_commit = 1'b0;
        w_wr.en = 1'b0;
        w_wr.addr = {~r_bank, r_widx[AW-1:0]};
        w_wr.data = w_rd;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_op   = t_op'(s_axis_tuser);
                    n_s    = s_axis_tdata[63:0];
                    n_e    = s_axis_tdata[127:64];
                    n_img  = s_axis_tdata[159:128];
                    n_b    = s_axis_tdata[223:160];
                    n_pc   = s_axis_tdata[287:224];
                    n_phase = PH_A;
                    n_ridx = '0;  n_widx = '0;
                    n_any = 1'b0;  n_ovf = 1'b0;  n_lf = 1'b0;
                    n_skip = 1'b0;  n_stat = STAT_DONE;
                    n_state = S_SCAN;
                    if ((n_op == OP_ADD || n_op == OP_REMOVE) &&
                            (s_axis_tdata[63:0] >= s_axis_tdata[127:64])) begin
                        n_skip = 1'b1;  n_stat = STAT_EMPTY;  n_state = S_FIN;
                    end else if (n_op == OP_ADD && r_cnt >= CW'(TABLE_ENTRIES)) begin
                        n_skip = 1'b1;  n_stat = STAT_FULL;  n_state = S_FIN;
                    end
                end
            end
            S_SCAN: begin
                if (w_issue) begin
                    n_ridx = r_ridx + 1'b1;
                    n_rv   = 1'b1;
                end
                // evaluate the entry read last cycle
                if (r_rv) begin
                    case (r_op)
                        OP_ADD: begin
                            w_emit = (r_phase == PH_A) ? (w_rd.start <= r_s)
                                                       : (w_rd.start > r_s);
                        end
                        OP_REMOVE: begin
                            case (r_phase)
                                PH_A: begin
                                    if (w_ov) begin
                                        n_any = 1'b1;
                                        w_emit = (w_rd.start < r_s);
                                        w_emit_data.stop = r_s;
                                    end else begin
                                        w_emit = (w_rd.start <= r_e);
                                    end
                                end
                                PH_B: begin
                                    w_emit = w_ov && (r_e < w_rd.stop);
                                    w_emit_data.start = r_e;
                                end
                                default: begin
                                    w_emit = !w_ov && (w_rd.start > r_e);
                                end
                            endcase
                        end
                        OP_REMOVE_IMAGE: begin
                            if (w_rd.image == r_img) begin
                                n_any = 1'b1;
                            end else begin
                                w_emit = 1'b1;
                            end
                        end
                        default: begin
                            if (w_rd.start <= r_pc) begin
                                n_lf = 1'b1;
                                n_lstop = w_rd.stop;
                                n_limg = w_rd.image;
                                n_lbase = w_rd.base;
                            end
                        end
                    endcase
                end
                // end of a pass over the live bank
                if (!w_issue && !r_rv) begin
                    n_ridx = '0;
                    case (r_op)
                        OP_ADD: begin
                            n_state = (r_phase == PH_A) ? S_INS : S_FIN;
                        end
                        OP_REMOVE: begin
                            case (r_phase)
                                PH_A: begin
                                    if (!r_any) begin
                                        n_skip = 1'b1;  n_stat = STAT_NONE;  n_state = S_FIN;
                                    end else begin
                                        n_phase = PH_B;
                                    end
                                end
                                PH_B: n_phase = PH_C;
                                default: n_state = S_FIN;
                            endcase
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_INS: begin
                w_emit = 1'b1;
                w_emit_data = '{start: r_s, stop: r_e, image: r_img, base: r_b};
                n_phase = PH_C;
                n_state = S_SCAN;
            end
            default: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_ohit = 1'b0;  n_oimg = '0;  n_ooff = '0;
                    n_ostat = r_stat;
                    n_state = S_IDLE;
                    if (!r_skip) begin
                        case (r_op)
                            OP_LOOKUP: begin
                                if (r_lf && (r_pc < r_lstop)) begin
                                    n_ohit = 1'b1;
                                    n_oimg = r_limg;
                                    n_ooff = r_pc - r_lbase;
                                end
                            end
                            OP_REMOVE: begin
                                n_ostat = r_ovf ? STAT_FULL : STAT_DONE;
                                w_commit = !r_ovf;
                            end
                            OP_REMOVE_IMAGE: begin
                                n_ostat = r_any ? STAT_DONE : STAT_NONE;
                                w_commit = r_any;
                            end
                            default: begin
                                w_commit = 1'b1;
                            end
                        endcase
                    end
                    if (w_commit) begin
                        n_bank = ~r_bank;
                        n_cnt = r_widx;
                    end
                end
            end
        endcase

        // write into the spare bank, or note the overflow
        if (w_emit) begin
            if (r_widx == CW'(TABLE_ENTRIES)) begin
                n_ovf = 1'b1;
            end else begin
                w_wr.en = 1'b1;
                w_wr.data = w_emit_data;
                n_widx = r_widx + 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_A;
            r_bank   <= 1'b0;
            r_cnt    <= '0;
            r_rv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_bank   <= n_bank;
            r_cnt    <= n_cnt;
            r_rv     <= n_rv;
            r_ovalid <= n_ovalid;
        end
    end

    // transaction payload and scan bookkeeping
    always_ff @(posedge i_clk) begin
        r_op <= n_op;  r_s <= n_s;  r_e <= n_e;  r_b <= n_b;  r_pc <= n_pc;
        r_img <= n_img;  r_ridx <= n_ridx;  r_widx <= n_widx;
        r_any <= n_any;  r_ovf <= n_ovf;  r_lf <= n_lf;
        r_skip <= n_skip;  r_stat <= n_stat;
        r_lstop <= n_lstop;  r_lbase <= n_lbase;  r_limg <= n_limg;
        r_ohit <= n_ohit;  r_oimg <= n_oimg;  r_ooff <= n_ooff;  r_ostat <= n_ostat;
    end

    `CRT_ASSERT_IMP(a_cnt_bound, 1'b1, r_cnt <= CW'(TABLE_ENTRIES), "entry count beyond table")
    `CRT_ASSERT_IMP(a_wr_in_range, w_wr.en, r_widx < CW'(TABLE_ENTRIES), "write past table end")
    `CRT_ASSERT_IMP(a_commit_ok, w_commit, !r_ovf, "bank swap after overflow")
    `CRT_ASSERT_NXT(a_busy_after_acc, w_in_acc, r_state != S_IDLE, "idle after accept")

endmodule
`default_nettype wire
